// ----- sv/nabs_pkg.sv -----
// ----------------------------------------------------------------------------
// nabs_pkg
// Shared constants and controller/datapath interface types for the
// no-data aware box smoother.
// ----------------------------------------------------------------------------
package nabs_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_KERNEL_DEF = 15;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int KSIZE_BITS  = 4;
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam int MEAN_BITS  = 24;
   localparam int COUNT_BITS = 8;
   localparam int FRAC_BITS  = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_SIZE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [KSIZE_BITS-1:0]  KSIZE_RESET  = 4'd3;
   // reset width is one bit wider than the 12-bit write field
   localparam logic [WIDTH_BITS:0]    WIDTH_RESET  = 13'd2048;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd512;

   localparam logic [MEAN_BITS-1:0] MEAN_MAX = 24'h7FFFFF;
   localparam logic [MEAN_BITS-1:0] MEAN_MIN = 24'h800000;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic accept;
      logic scan_init;
      logic scan_step;
      logic div_init;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_out;
      logic scan_last;
      logic div_last;
      logic out_busy;
   } sts_type;

endpackage

// ----- sv/nodata_aware_box_smoother.sv -----
// ----------------------------------------------------------------------------
// nodata_aware_box_smoother
// 2-D box mean over nonzero pixels of a raster stream, edge-truncated window.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one per transaction;
// zero means no data. Each result on the rsp_ channel is the Q15.8 mean
// and count of the nonzero pixels in the k-by-k window around one pixel,
// lagging the input by h lines plus h pixels (h = (k-1)/2). After the
// last pixel of a frame, that many further transactions (req_flush) drain
// the remaining results; last_of_frame marks the final one.
// A transaction that yields no result leaves the block ready. One that
// yields a result runs a scan of the n = rows x columns words of the cut
// window (at most k*k), read from the line store one word per cycle, and
// then NW (32 by default) quotient bits of the divider, one a cycle.
// The result sits in an output register; the block takes the next
// transaction while it waits, but holds off during the scan and divide
// and when a new result is ready while the old one is still stalled.
// Reset clears control and the configuration (kernel 3, width 2048,
// height 512). Writing any register restarts the frame.
// ----------------------------------------------------------------------------
module nodata_aware_box_smoother #(
   parameter int MAX_WIDTH  = nabs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = nabs_pkg::MAX_KERNEL_DEF,
   parameter int PIXEL_BITS = nabs_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [PIXEL_BITS-1:0]          req_pixel,
   input  logic                                  req_flush,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [nabs_pkg::MEAN_BITS-1:0] rsp_mean_value,
   output logic [nabs_pkg::COUNT_BITS-1:0]       rsp_valid_count,
   output logic                                  rsp_last_of_frame,
   input  logic                                  csr_wr_en,
   input  logic [nabs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [nabs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CNT_CAP = (MAX_KERNEL * MAX_KERNEL > 255) ? 255 : MAX_KERNEL * MAX_KERNEL;

   nabs_pkg::cmd_type cmd;
   nabs_pkg::sts_type sts;

   // flush only tags drain transactions; position counters already tell
   // pixels from drain items
   logic flush_seen;
   assign flush_seen = req_flush;

   nabs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   nabs_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_pixel         (req_pixel),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_valid_count   (rsp_valid_count),
      .rsp_last_of_frame (rsp_last_of_frame),
      .cmd               (cmd),
      .sts               (sts)
   );

   a_empty_window_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_count == '0 |-> rsp_mean_value == '0)
      else $error("nonzero mean with empty window");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_valid_count) <= CNT_CAP)
      else $error("window count exceeds kernel area");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && sts.need_out |=> !req_ready)
      else $error("transaction accepted during window scan");

   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && flush_seen && !sts.need_out |=> req_ready)
      else $error("drain transaction without result stalled input");

endmodule

// ----- sv/nabs_ram.sv -----
// ----------------------------------------------------------------------------
// nabs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nabs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/nabs_ctrl.sv -----
// ----------------------------------------------------------------------------
// nabs_ctrl
// Sequencer: accept, window scan, divide, result hand-off.
// ----------------------------------------------------------------------------
module nabs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nabs_pkg::sts_type sts,
   output nabs_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DRAIN,
      DIV_INIT,
      DIV,
      OUTPUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      req_ready     = (state_ff == IDLE);
      case (state_ff)
         IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.need_out) begin
               cmd.scan_init = 1'b1;
               state_in      = SCAN;
            end
         end
         SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = DRAIN;
            end
         end
         // last read word is accumulated here
         DRAIN: begin
            state_in = DIV_INIT;
         end
         DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = OUTPUT;
            end
         end
         OUTPUT: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/nabs_datapath.sv -----
// ----------------------------------------------------------------------------
// nabs_datapath
// Config registers, raster counters, line store, window accumulator,
// bit-serial divider and output register.
// ----------------------------------------------------------------------------
module nabs_datapath #(
   parameter int MAX_WIDTH  = nabs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_KERNEL = nabs_pkg::MAX_KERNEL_DEF,
   parameter int PIXEL_BITS = nabs_pkg::PIXEL_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [PIXEL_BITS-1:0]         req_pixel,
   input  logic                                 csr_wr_en,
   input  logic [nabs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [nabs_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [nabs_pkg::MEAN_BITS-1:0] rsp_mean_value,
   output logic [nabs_pkg::COUNT_BITS-1:0]      rsp_valid_count,
   output logic                                 rsp_last_of_frame,
   input  nabs_pkg::cmd_type                    cmd,
   output nabs_pkg::sts_type                    sts
);

   localparam int RING  = MAX_KERNEL + 1;
   localparam int RB    = $clog2(RING);
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int CX    = CB + 2;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AB    = $clog2(DEPTH);
   localparam int HTB   = nabs_pkg::HEIGHT_BITS;
   localparam int TB    = WW + HTB + 1;
   localparam int HB    = $clog2(MAX_KERNEL);
   localparam int SW    = PIXEL_BITS + $clog2(MAX_KERNEL * MAX_KERNEL);
   localparam int CW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
   localparam int NW    = SW + nabs_pkg::FRAC_BITS;
   localparam int DB    = $clog2(NW + 1);
   localparam int MX    = ((NW > nabs_pkg::MEAN_BITS) ? NW : nabs_pkg::MEAN_BITS) + 1;

   // configuration
   logic [nabs_pkg::KSIZE_BITS-1:0]  ksize_ff;
   logic [nabs_pkg::WIDTH_BITS:0]    iwidth_ff;
   logic [nabs_pkg::HEIGHT_BITS-1:0] iheight_ff;
   logic                             restart;

   logic [7:0]     k_eff;
   logic [HB-1:0]  half;
   logic [WW-1:0]  w_eff;
   logic [HTB-1:0] h_eff;
   logic [TB-1:0]  total, total_m1, delay;

   // raster position
   logic [TB-1:0]  in_idx_ff, out_idx_ff;
   logic [CB-1:0]  in_col_ff, out_col_ff;
   logic [RB-1:0]  in_ring_ff, out_ring_ff;
   logic [HTB-1:0] out_row_ff;
   logic           in_col_wrap, out_col_wrap, last;

   // window scan
   logic [HTB-1:0] r0, r1, srow_ff, r1_ff;
   logic [HTB:0]   r1_sum;
   logic [CX-1:0]  cx, hx, c1_sum;
   logic [CB-1:0]  c0, c1, scol_ff, c0_ff, c1_ff;
   logic [RB-1:0]  dr, ring0, sring_ff;
   logic [RB:0]    ring_sum;
   logic           rd_pend_ff;

   logic                         wr_en;
   logic [AB-1:0]                wr_addr, rd_addr;
   logic signed [PIXEL_BITS-1:0] rd_data;

   // accumulate and divide
   logic signed [SW-1:0] sum_ff;
   logic [CW-1:0]        cnt_ff;
   logic [SW-1:0]        mag;
   logic [NW-1:0]        quo_ff;
   logic [CW-1:0]        rem_ff;
   logic [CW:0]          rem_sh;
   logic                 rem_ge;
   logic                 neg_ff;
   logic [DB-1:0]        dstep_ff;
   logic [MX-1:0]        qx, mean_x;

   logic                                 rsp_valid_ff;
   logic [nabs_pkg::MEAN_BITS-1:0]       mean_ff, mean_in;
   logic [nabs_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   logic                                 last_ff;

   // effective configuration
   always_comb begin
      k_eff = {4'b0, ksize_ff};
      if (k_eff < 8'd3) begin
         k_eff = 8'd3;
      end
      if (k_eff > 8'(MAX_KERNEL)) begin
         k_eff = 8'(MAX_KERNEL);
      end
      if (!k_eff[0]) begin
         k_eff = k_eff - 8'd1;
      end
      if (32'(iwidth_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else if (iwidth_ff == '0) begin
         w_eff = WW'(1);
      end else begin
         w_eff = WW'(iwidth_ff);
      end
      h_eff = (iheight_ff == '0) ? HTB'(1) : iheight_ff;
   end

   assign half     = HB'(k_eff >> 1);
   assign total    = TB'(w_eff) * TB'(h_eff);
   assign total_m1 = total - TB'(1);
   assign delay    = TB'(half) * TB'(w_eff) + TB'(half);

   assign restart = csr_wr_en && (csr_index == nabs_pkg::REG_KERNEL_SIZE ||
                                  csr_index == nabs_pkg::REG_IMAGE_WIDTH ||
                                  csr_index == nabs_pkg::REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff   <= nabs_pkg::KSIZE_RESET;
         iwidth_ff  <= nabs_pkg::WIDTH_RESET;
         iheight_ff <= nabs_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            nabs_pkg::REG_KERNEL_SIZE:  ksize_ff   <= csr_wdata[nabs_pkg::KSIZE_BITS-1:0];
            nabs_pkg::REG_IMAGE_WIDTH:  iwidth_ff  <= {1'b0, csr_wdata[nabs_pkg::WIDTH_BITS-1:0]};
            nabs_pkg::REG_IMAGE_HEIGHT: iheight_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // line store write on every in-frame transaction
   assign wr_en   = cmd.accept && (in_idx_ff < total);
   assign wr_addr = AB'(in_ring_ff) * AB'(MAX_WIDTH) + AB'(in_col_ff);
   assign rd_addr = AB'(sring_ff) * AB'(MAX_WIDTH) + AB'(scol_ff);

   nabs_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (cmd.scan_step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign in_col_wrap  = (WW'(in_col_ff) + WW'(1)) >= w_eff;
   assign out_col_wrap = (WW'(out_col_ff) + WW'(1)) >= w_eff;
   assign last         = out_idx_ff >= total_m1;

   always_ff @(posedge clock) begin
      if (reset || restart || (cmd.load_out && last)) begin
         in_idx_ff   <= '0;
         in_col_ff   <= '0;
         in_ring_ff  <= '0;
         out_idx_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_ring_ff <= '0;
      end else begin
         if (cmd.accept) begin
            in_idx_ff <= in_idx_ff + TB'(1);
            if (in_col_wrap) begin
               in_col_ff  <= '0;
               in_ring_ff <= (32'(in_ring_ff) == RING - 1) ? '0 : in_ring_ff + RB'(1);
            end else begin
               in_col_ff <= in_col_ff + CB'(1);
            end
         end
         if (cmd.load_out) begin
            out_idx_ff <= out_idx_ff + TB'(1);
            if (out_col_wrap) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + HTB'(1);
               out_ring_ff <= (32'(out_ring_ff) == RING - 1) ? '0 : out_ring_ff + RB'(1);
            end else begin
               out_col_ff <= out_col_ff + CB'(1);
            end
         end
      end
   end

   // cut window bounds of the next output pixel
   always_comb begin
      r0     = (out_row_ff > HTB'(half)) ? out_row_ff - HTB'(half) : '0;
      dr     = RB'(out_row_ff - r0);
      r1_sum = (HTB+1)'(out_row_ff) + (HTB+1)'(half);
      r1     = (r1_sum > (HTB+1)'(h_eff - HTB'(1))) ? h_eff - HTB'(1) : r1_sum[HTB-1:0];
      cx     = CX'(out_col_ff);
      hx     = CX'(half);
      c0     = (cx > hx) ? CB'(cx - hx) : '0;
      c1_sum = cx + hx;
      c1     = (c1_sum > CX'(w_eff - WW'(1))) ? CB'(w_eff - WW'(1)) : CB'(c1_sum);
      ring_sum = (out_ring_ff >= dr) ? (RB+1)'(out_ring_ff - dr)
                                     : (RB+1)'(out_ring_ff) + (RB+1)'(RING) - (RB+1)'(dr);
      ring0  = RB'(ring_sum);
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         srow_ff  <= r0;
         sring_ff <= ring0;
         scol_ff  <= c0;
         c0_ff    <= c0;
         c1_ff    <= c1;
         r1_ff    <= r1;
      end else if (cmd.scan_step) begin
         if (scol_ff == c1_ff) begin
            scol_ff  <= c0_ff;
            srow_ff  <= srow_ff + HTB'(1);
            sring_ff <= (32'(sring_ff) == RING - 1) ? '0 : sring_ff + RB'(1);
         end else begin
            scol_ff <= scol_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_step;
      end
   end

   // sum and count of nonzero pixels
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (rd_pend_ff && rd_data != '0) begin
         sum_ff <= sum_ff + SW'(rd_data);
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   // restoring divide of |sum| * 256 by count, one quotient bit per cycle
   assign mag    = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign rem_ge = rem_sh >= (CW+1)'(cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         neg_ff   <= sum_ff[SW-1];
         quo_ff   <= {mag, {nabs_pkg::FRAC_BITS{1'b0}}};
         rem_ff   <= '0;
         dstep_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= rem_ge ? CW'(rem_sh - (CW+1)'(cnt_ff)) : CW'(rem_sh);
         quo_ff   <= {quo_ff[NW-2:0], rem_ge};
         dstep_ff <= dstep_ff + DB'(1);
      end
   end

   // saturate, apply sign; zero mean for an empty window
   always_comb begin
      qx = MX'(quo_ff);
      if (!neg_ff) begin
         mean_x = (qx > MX'(nabs_pkg::MEAN_MAX)) ? MX'(nabs_pkg::MEAN_MAX) : qx;
      end else begin
         mean_x = (qx > MX'(nabs_pkg::MEAN_MIN)) ? MX'(nabs_pkg::MEAN_MIN) : MX'(-qx);
      end
      mean_in  = (cnt_ff == '0) ? '0 : mean_x[nabs_pkg::MEAN_BITS-1:0];
      count_in = (32'(cnt_ff) > 32'(nabs_pkg::COUNT_MAX)) ? nabs_pkg::COUNT_MAX
                                                         : nabs_pkg::COUNT_BITS'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mean_ff  <= mean_in;
         count_ff <= count_in;
         last_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_value    = mean_ff;
   assign rsp_valid_count   = count_ff;
   assign rsp_last_of_frame = last_ff;

   assign sts.need_out  = in_idx_ff >= delay;
   assign sts.scan_last = (srow_ff == r1_ff) && (scol_ff == c1_ff);
   assign sts.div_last  = dstep_ff == DB'(NW - 1);
   assign sts.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule
